[src/base64_stream_codec_defines.svh]
// Assertion helpers shared by the codec. Every property samples on clk
// and is switched off while rst_n is low.
`ifndef BASE64_STREAM_CODEC_DEFINES_SVH
`define BASE64_STREAM_CODEC_DEFINES_SVH

// Same-cycle implication.
`define B64C_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64c assertion failed");

// Next-cycle implication.
`define B64C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64c assertion failed");

`endif

[src/b64c_pkg.sv]
package b64c_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned GROUP_W  = 24;

    localparam logic [BYTE_W-1:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;  // '/'

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // One finished group waiting to be sent as a run of results.
    typedef struct packed {
        logic                 enc;           // characters (1) or bytes (0)
        logic [GROUP_W-1:0]   bits;
        logic [1:0]           last_idx;      // index of the final result of the run
        logic [1:0]           data_last_idx; // encode: later indexes are pads
        logic                 last;
        logic                 err;
    } b64c_burst_t;

    typedef struct packed {
        logic                ok;
        logic [SEXTET_W-1:0] val;
    } b64c_sextet_t;

    function automatic logic [BYTE_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
        logic [BYTE_W-1:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd71 + {2'b00, v};
        end else if (v < 6'd62) begin
            c = {2'b00, v} - 8'd4;
        end else if (v == 6'd62) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

    function automatic b64c_sextet_t char_sextet(input logic [BYTE_W-1:0] c);
        b64c_sextet_t s;
        s.ok  = 1'b1;
        s.val = '0;
        if (c >= 8'd65 && c <= 8'd90) begin
            s.val = 6'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            s.val = 6'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            s.val = 6'(c + 8'd4);
        end else if (c == CHAR_PLUS) begin
            s.val = 6'd62;
        end else if (c == CHAR_SLASH) begin
            s.val = 6'd63;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

[src/b64c_if.sv]
interface b64c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;

    modport source (output valid, output out_byte, output out_last, output out_error,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input out_error,
                    output ready);
endinterface

[src/b64c_serializer.sv]
module b64c_serializer
    import b64c_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  b64c_burst_t  burst,
    input  logic         load,
    output logic         can_load,
    b64c_out_if.source   out_ch
);

    logic        busy_reg;
    logic [1:0]  idx_reg;
    b64c_burst_t burst_reg;
    logic        drain_done;
    logic [SEXTET_W-1:0] sextet;
    logic [BYTE_W-1:0]   data_byte;

    assign drain_done = busy_reg && out_ch.ready && (idx_reg == burst_reg.last_idx);
    assign can_load   = !busy_reg || drain_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (drain_done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && out_ch.ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

    // Pick the sextet or byte for the current result index.
    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = burst_reg.bits[23:18];
            2'd1:    sextet = burst_reg.bits[17:12];
            2'd2:    sextet = burst_reg.bits[11:6];
            default: sextet = burst_reg.bits[5:0];
        endcase
        case (idx_reg)
            2'd0:    data_byte = burst_reg.bits[23:16];
            2'd1:    data_byte = burst_reg.bits[15:8];
            2'd2:    data_byte = burst_reg.bits[7:0];
            default: data_byte = '0;
        endcase
    end

    assign out_ch.valid     = busy_reg;
    assign out_ch.out_byte  = !burst_reg.enc ? data_byte
                            : (idx_reg > burst_reg.data_last_idx) ? CHAR_PAD
                            : sextet_char(sextet);
    assign out_ch.out_last  = burst_reg.last && (idx_reg == burst_reg.last_idx);
    assign out_ch.out_error = burst_reg.err;

endmodule

[src/base64_stream_codec.sv]
// Latency: the first result of a group is offered the cycle after the item that closes it.
// Throughput: one item accepted per cycle while gathering; one result sent per cycle while
// the receiver is ready. Encode: 3 items give 4 results, so the result port limits a steady
// stream. Decode: 4 items give 3 results, so the item port limits it.
// Reset (rst_n low, async): mode returns to encode, the partial group and result run drop.
`include "base64_stream_codec_defines.svh"

module base64_stream_codec
    import b64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    b64c_in_if.sink    in_ch,
    b64c_out_if.source out_ch
);

    // Stream state: mode plus the group being gathered.
    logic               mode_reg;
    logic [GROUP_W-1:0] group_bits_reg, group_bits_next;
    logic [1:0]         group_count_reg, group_count_next;
    logic [1:0]         pad_marks_reg, pad_marks_next;
    logic               bad_seen_reg, bad_seen_next;

    logic         accept;
    logic         completes;
    logic         can_load;
    b64c_burst_t  burst;

    // Decode-side helpers.
    logic               is_pad;
    b64c_sextet_t       dec;
    logic [SEXTET_W-1:0] sxt;
    logic [GROUP_W-1:0] merged;
    logic [1:0]         pad_upd;
    logic               bad_upd;

    // An item that closes a group needs the result run to be free (or freeing
    // this cycle); any other item is gathered at once.
    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = can_load || !completes;

    always_comb
    begin
        is_pad  = (in_ch.in_byte == CHAR_PAD);
        dec     = char_sextet(in_ch.in_byte);
        sxt     = (is_pad || !dec.ok) ? '0 : dec.val;
        bad_upd = bad_seen_reg || (!is_pad && !dec.ok);
        // Pads only count toward dropped bytes in the third and fourth places.
        pad_upd = (is_pad && group_count_reg[1]) ? pad_marks_reg + 2'd1 : pad_marks_reg;

        merged = group_bits_reg;
        burst  = '0;
        if (mode_reg == MODE_ENCODE)
        begin
            case (group_count_reg)
                2'd0:    merged = group_bits_reg | {in_ch.in_byte, 16'd0};
                2'd1:    merged = group_bits_reg | {8'd0, in_ch.in_byte, 8'd0};
                default: merged = group_bits_reg | {16'd0, in_ch.in_byte};
            endcase
            completes           = (group_count_reg == 2'd2) || in_ch.in_last;
            burst.enc           = 1'b1;
            burst.bits          = merged;
            burst.last_idx      = 2'd3;
            // Data characters run to index count+1; the rest are pads.
            burst.data_last_idx = group_count_reg + 2'd1;
            burst.last          = in_ch.in_last;
            burst.err           = 1'b0;
        end
        else
        begin
            case (group_count_reg)
                2'd0:    merged = group_bits_reg | {sxt, 18'd0};
                2'd1:    merged = group_bits_reg | {6'd0, sxt, 12'd0};
                2'd2:    merged = group_bits_reg | {12'd0, sxt, 6'd0};
                default: merged = group_bits_reg | {18'd0, sxt};
            endcase
            completes = (group_count_reg == 2'd3) || in_ch.in_last;
            burst.enc = 1'b0;
            burst.last = in_ch.in_last;
            if (group_count_reg == 2'd3)
            begin
                burst.bits     = merged;
                // Trailing pads drop bytes from the final group only.
                burst.last_idx = in_ch.in_last ? 2'd2 - pad_upd : 2'd2;
                burst.err      = bad_upd;
            end
            else
            begin
                // Stream ended mid-group: one zero byte flagged as an error.
                burst.bits     = '0;
                burst.last_idx = 2'd0;
                burst.err      = 1'b1;
            end
        end

        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        pad_marks_next   = pad_marks_reg;
        bad_seen_next    = bad_seen_reg;
        if (accept)
        begin
            if (in_ch.in_last)
            begin
                // End of stream: drop everything but the mode.
                group_bits_next  = '0;
                group_count_next = '0;
                pad_marks_next   = '0;
                bad_seen_next    = 1'b0;
            end
            else if (completes)
            begin
                group_bits_next  = '0;
                group_count_next = '0;
                pad_marks_next   = '0;
                bad_seen_next    = (mode_reg == MODE_DECODE) ? bad_upd : bad_seen_reg;
            end
            else
            begin
                group_bits_next  = merged;
                group_count_next = group_count_reg + 2'd1;
                if (mode_reg == MODE_DECODE)
                begin
                    pad_marks_next = pad_upd;
                    bad_seen_next  = bad_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_ENCODE;
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            pad_marks_reg   <= '0;
            bad_seen_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            // A mode write drops any partial stream.
            mode_reg        <= cfg_wdata;
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            pad_marks_reg   <= '0;
            bad_seen_reg    <= 1'b0;
        end
        else
        begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            pad_marks_reg   <= pad_marks_next;
            bad_seen_reg    <= bad_seen_next;
        end
    end

    // Result run: hold a closed group and send it one result per cycle while the receiver is ready.
    b64c_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .burst    (burst),
        .load     (accept && completes),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

    `B64C_ASSERT_IMPL(a_enc_no_error, out_ch.valid && (mode_reg == MODE_ENCODE), !out_ch.out_error)
    `B64C_ASSERT_NEXT(a_last_clears, accept && in_ch.in_last,
        (group_count_reg == 2'd0) && (pad_marks_reg == 2'd0) && !bad_seen_reg)
    `B64C_ASSERT_NEXT(a_group_sends, accept && completes, out_ch.valid)

endmodule

[tb/sv/base64_stream_codec_tb.sv]
`timescale 1ns / 100ps

module base64_stream_codec_tb
    import b64c_pkg::*;
();

    // One result as it leaves the codec: character or byte, end mark, error flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } codec_res_t;

    // One line of the directed table. A config line carries the mode in data[0].
    // A line with n_typed != 0 brings its own expected results; the rest lean on
    // the running model of the codec.
    typedef struct packed {
        logic                 kind_cfg;
        logic [7:0]           data;
        logic                 last;
        logic [2:0]           n_typed;
        codec_res_t [0:3]     typed;
    } stim_row_t;

    localparam codec_res_t NO_RES        = '0;
    localparam int         HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int         WATCHDOG_MAX  = 2000;  // cycles with no handshake at all
    localparam int         PHASE_ITEMS   = 48;
    localparam int         NUM_PHASES    = 8;
    localparam int         SETTLE_CYCLES = 4;     // result run starts the cycle after its item
    localparam int         TAIL_CYCLES   = 16;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;

    b64c_in_if  in_ch ();
    b64c_out_if out_ch ();

    base64_stream_codec u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Running model of the codec: mode register plus the group being gathered.
    logic        m_mode   = MODE_ENCODE;
    logic [23:0] grp_bits = '0;
    logic [1:0]  grp_cnt  = '0;
    logic [1:0]  pad_cnt  = '0;
    logic        bad_flag = 1'b0;

    codec_res_t  step_out [$];   // results caused by the item just accepted
    codec_res_t  due_out  [$];   // results still owed by the codec, oldest first
    stim_row_t   dir_tab  [$];
    stim_row_t   drv_row;        // line currently offered on the item port
    int          n_fail   = 0;
    logic        hold_req = 1'b0;
    logic        calm     = 1'b0;

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic codec_res_t res(input logic [7:0] d, input logic l, input logic e);
        codec_res_t r;
        r.data = d;
        r.last = l;
        r.err  = e;
        return r;
    endfunction

    function automatic stim_row_t plain(input logic [7:0] d, input logic l);
        stim_row_t r;
        r         = '0;
        r.data    = d;
        r.last    = l;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] d, input logic l,
                                            input int n, input codec_res_t [0:3] exp_res);
        stim_row_t r;
        r         = plain(d, l);
        r.n_typed = 3'(n);
        r.typed   = exp_res;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic m);
        stim_row_t r;
        r          = '0;
        r.kind_cfg = 1'b1;
        r.data[0]  = m;
        return r;
    endfunction

    // Sextet to alphabet character.
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        if (v < 6'd26)
        begin
            return 8'("A") + {2'b00, v};
        end
        if (v < 6'd52)
        begin
            return 8'("a") + {2'b00, v} - 8'd26;
        end
        if (v < 6'd62)
        begin
            return 8'("0") + {2'b00, v} - 8'd52;
        end
        return (v == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // Alphabet character to sextet; bit 6 set marks a character outside it.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return 7'(c - 8'("A"));
        end
        if (c >= "a" && c <= "z")
        begin
            return 7'(c - 8'("a") + 8'd26);
        end
        if (c >= "0" && c <= "9")
        begin
            return 7'(c - 8'("0") + 8'd52);
        end
        if (c == CHAR_PLUS)
        begin
            return 7'd62;
        end
        if (c == CHAR_SLASH)
        begin
            return 7'd63;
        end
        return 7'd64;
    endfunction

    function automatic void clear_group();
        grp_bits = '0;
        grp_cnt  = '0;
        pad_cnt  = '0;
        bad_flag = 1'b0;
    endfunction

    // Advance the model by one item; the results it causes land in step_out.
    function automatic void b64_transcode(input logic [7:0] d, input logic l);
        int          have;
        int          nbytes;
        logic [6:0]  sx;
        logic [5:0]  s;
        logic [7:0]  ch;
        have = int'(grp_cnt) + 1;
        if (m_mode == MODE_ENCODE)
        begin
            grp_bits = grp_bits | (24'(d) << ((2 - int'(grp_cnt)) * 8));
            if (have < 3 && !l)
            begin
                grp_cnt = 2'(have);
                return;
            end
            // have + 1 data characters, then pads up to four
            for (int i = 0; i < 4; i++)
            begin
                ch = (i < have + 1) ? sextet_to_char(6'(grp_bits >> ((3 - i) * 6))) : CHAR_PAD;
                step_out.push_back(res(ch, l && i == 3, 1'b0));
            end
            clear_group();
            return;
        end
        // decode
        if (d == CHAR_PAD)
        begin
            s = '0;
            if (grp_cnt >= 2)
            begin
                pad_cnt = pad_cnt + 2'd1;
            end
        end
        else
        begin
            sx = char_to_sextet(d);
            if (sx[6])
            begin
                bad_flag = 1'b1;
                s        = '0;
            end
            else
            begin
                s = sx[5:0];
            end
        end
        grp_bits = grp_bits | (24'(s) << ((3 - int'(grp_cnt)) * 6));
        if (have < 4)
        begin
            if (l)
            begin
                // stream ended mid-group: one flagged result
                step_out.push_back(res(8'h00, 1'b1, 1'b1));
                clear_group();
            end
            else
            begin
                grp_cnt = 2'(have);
            end
            return;
        end
        nbytes = l ? 3 - int'(pad_cnt) : 3;
        for (int i = 0; i < nbytes; i++)
        begin
            step_out.push_back(res(8'(grp_bits >> ((2 - i) * 8)), l && (i + 1 == nbytes),
                                   bad_flag));
        end
        if (l)
        begin
            clear_group();
        end
        else
        begin
            grp_bits = '0;
            grp_cnt  = '0;
            pad_cnt  = '0;
        end
    endfunction

    // Sample both ports at the rising edge: update the model on every accepted
    // item and config write, check every accepted result against the oldest
    // one owed.
    always @(posedge clk)
    begin
        codec_res_t got;
        codec_res_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                m_mode = cfg_wdata;
                clear_group();
            end
            if (in_ch.valid && in_ch.ready)
            begin
                step_out.delete();
                b64_transcode(in_ch.in_byte, in_ch.in_last);
                // typed lines override the model with values read off by hand
                if (drv_row.n_typed != 0)
                begin
                    for (int k = 0; k < int'(drv_row.n_typed); k++)
                    begin
                        due_out.push_back(drv_row.typed[k]);
                    end
                end
                else
                begin
                    foreach (step_out[k])
                    begin
                        due_out.push_back(step_out[k]);
                    end
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = res(out_ch.out_byte, out_ch.out_last, out_ch.out_error);
                if (due_out.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h out_last %0b out_error %0b",
                           got.data, got.last, got.err);
                    n_fail++;
                end
                else
                begin
                    want = due_out.pop_front();
                    if (got.data !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, got.data);
                        n_fail++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("out_last: expected %0b, got %0b", want.last, got.last);
                        n_fail++;
                    end
                    if (got.err !== want.err)
                    begin
                        $error("out_error: expected %0b, got %0b", want.err, got.err);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_MAX)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: ready changes at the falling edge. Stall in random bursts, hold
    // off for a long stretch once on request, and stay open in the calm tail.
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req     = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                n            = $urandom_range(1, 17);
                out_ch.ready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Offer one item at the falling edge, maybe after a random gap, and hold it
    // until the codec takes it. Valid stays high into the next item unless a gap drops it.
    task automatic send_item(input stim_row_t row);
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 17);
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        drv_row       = row;
        in_ch.in_byte = row.data;
        in_ch.in_last = row.last;
        in_ch.valid   = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
    endtask

    // Write the mode only once the codec owes nothing and has settled.
    task automatic write_mode(input logic m);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (due_out.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Build and send one random stream for the given mode; count its items.
    task automatic send_stream(input logic m, inout int sent);
        logic [7:0] seq [$];
        int         kind;
        int         n;
        int         npad;
        if (m == MODE_ENCODE)
        begin
            n = $urandom_range(1, 10);
            repeat (n) seq.push_back(8'($urandom));
        end
        else
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6 || kind == 9)
            begin
                // well-formed groups; the last one may carry one or two pads
                n = 4 * $urandom_range(1, 3);
                repeat (n) seq.push_back(sextet_to_char(6'($urandom)));
                if (kind <= 6)
                begin
                    npad = $urandom_range(0, 2);
                    for (int i = 0; i < npad; i++)
                    begin
                        seq[n - 1 - i] = CHAR_PAD;
                    end
                end
                else
                begin
                    // corrupt one place: stray pad or any byte at all
                    seq[$urandom_range(0, n - 1)] =
                        $urandom_range(0, 1) ? CHAR_PAD : 8'($urandom);
                end
            end
            else if (kind == 7)
            begin
                // length not a multiple of four
                n = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
                repeat (n) seq.push_back(sextet_to_char(6'($urandom)));
            end
            else
            begin
                // noise
                n = $urandom_range(1, 10);
                repeat (n) seq.push_back(8'($urandom));
            end
        end
        foreach (seq[i])
        begin
            send_item(plain(seq[i], i == seq.size() - 1));
        end
        sent += seq.size();
    endtask

    initial
    begin
        logic cur_mode;
        int   sent;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        drv_row       = '0;

        // Encode, straight out of reset: all-ones group, lone 0xFF with two pads,
        // two zero bytes with one pad, then a stray byte that the mode write drops.
        dir_tab.push_back(plain(8'hFF, 1'b0));
        dir_tab.push_back(plain(8'hFF, 1'b0));
        dir_tab.push_back(typed_row(8'hFF, 1'b0, 4, {res(CHAR_SLASH, 1'b0, 1'b0),
            res(CHAR_SLASH, 1'b0, 1'b0), res(CHAR_SLASH, 1'b0, 1'b0),
            res(CHAR_SLASH, 1'b0, 1'b0)}));
        dir_tab.push_back(typed_row(8'hFF, 1'b1, 4, {res(CHAR_SLASH, 1'b0, 1'b0),
            res("w", 1'b0, 1'b0), res(CHAR_PAD, 1'b0, 1'b0), res(CHAR_PAD, 1'b1, 1'b0)}));
        dir_tab.push_back(plain(8'h00, 1'b0));
        dir_tab.push_back(typed_row(8'h00, 1'b1, 4, {res("A", 1'b0, 1'b0),
            res("A", 1'b0, 1'b0), res("A", 1'b0, 1'b0), res(CHAR_PAD, 1'b1, 1'b0)}));
        dir_tab.push_back(plain(8'h80, 1'b0));
        dir_tab.push_back(cfg_row(MODE_DECODE));
        // Decode: all-ones group, then "AA==" closing the stream with one byte.
        dir_tab.push_back(plain(CHAR_SLASH, 1'b0));
        dir_tab.push_back(plain(CHAR_SLASH, 1'b0));
        dir_tab.push_back(plain(CHAR_SLASH, 1'b0));
        dir_tab.push_back(typed_row(CHAR_SLASH, 1'b0, 3, {res(8'hFF, 1'b0, 1'b0),
            res(8'hFF, 1'b0, 1'b0), res(8'hFF, 1'b0, 1'b0), NO_RES}));
        dir_tab.push_back(plain("A", 1'b0));
        dir_tab.push_back(plain("A", 1'b0));
        dir_tab.push_back(plain(CHAR_PAD, 1'b0));
        dir_tab.push_back(typed_row(CHAR_PAD, 1'b1, 1, {res(8'h00, 1'b1, 1'b0),
            NO_RES, NO_RES, NO_RES}));
        // Stream ending after three characters, then one made of a lone bad character.
        dir_tab.push_back(plain("Q", 1'b0));
        dir_tab.push_back(plain("Q", 1'b0));
        dir_tab.push_back(typed_row(CHAR_PAD, 1'b1, 1, {res(8'h00, 1'b1, 1'b1),
            NO_RES, NO_RES, NO_RES}));
        dir_tab.push_back(typed_row(8'h00, 1'b1, 1, {res(8'h00, 1'b1, 1'b1),
            NO_RES, NO_RES, NO_RES}));
        // Pad in first place, bad character, then a final group with pads in the
        // second and fourth places; the bad mark stays until the stream ends.
        dir_tab.push_back(plain(CHAR_PAD, 1'b0));
        dir_tab.push_back(plain("W", 1'b0));
        dir_tab.push_back(plain("*", 1'b0));
        dir_tab.push_back(plain("A", 1'b0));
        dir_tab.push_back(plain("A", 1'b0));
        dir_tab.push_back(plain(CHAR_PAD, 1'b0));
        dir_tab.push_back(plain("A", 1'b0));
        dir_tab.push_back(plain(CHAR_PAD, 1'b1));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind_cfg)
            begin
                write_mode(dir_tab[i].data[0]);
            end
            else
            begin
                send_item(dir_tab[i]);
            end
        end

        // Random phases alternate the mode. The first one asks the receiver for
        // a long hold-off so the codec backs up; the last one runs with no gaps.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            cur_mode = (phase % 2 == 0) ? MODE_ENCODE : MODE_DECODE;
            write_mode(cur_mode);
            if (phase == 0)
            begin
                hold_req = 1'b1;
            end
            if (phase == NUM_PHASES - 1)
            begin
                calm = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_stream(cur_mode, sent);
            end
            // sometimes leave a partial group for the next mode write to drop
            if (phase < NUM_PHASES - 1 && $urandom_range(0, 1) == 1)
            begin
                repeat ($urandom_range(1, (cur_mode == MODE_ENCODE) ? 2 : 3))
                begin
                    send_item(plain(8'($urandom), 1'b0));
                end
            end
        end

        // Drain: drop valid, wait for every owed result, then let the tail settle.
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (due_out.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_fail == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/b64c_pkg.sv
src/b64c_if.sv
src/b64c_serializer.sv
src/base64_stream_codec.sv
tb/sv/base64_stream_codec_tb.sv
